// ===== rtl/wrv_pkg.sv =====
package wrv_pkg;

  // Front-end classification of one incoming item
  typedef enum logic [1:0] {
    KIND_ACCEPT,
    KIND_ZERO,
    KIND_REJECT
  } kind_t;

  typedef struct packed {
    logic [31:0] value;
    logic [14:0] weight;
    kind_t       kind;
  } item_t;

  typedef struct packed {
    logic [31:0] mean;
    logic [31:0] pop_sd;
    logic [31:0] samp_sd;
    logic        rejected;
    logic        undef;
    logic        empty;
  } result_t;

endpackage

// ===== rtl/wrv_front.sv =====
module wrv_front import wrv_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] value,
  input  logic [15:0] weight,
  output logic        full,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  item_t         item_in;
  logic          do_push;
  logic          do_pop;

  // Classify on the way in
  always_comb begin
    item_in.value  = value;
    item_in.weight = weight[14:0];
    if (weight[15]) begin
      item_in.kind = KIND_REJECT;
    end else if (weight == 16'd0) begin
      item_in.kind = KIND_ZERO;
    end else begin
      item_in.kind = KIND_ACCEPT;
    end
  end

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/wrv_div.sv =====
module wrv_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] hi,
  input  logic [63:0] lo,
  input  logic [63:0] dvs,
  output logic        busy,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] rem;
  logic [63:0] dvd;
  logic [5:0]  cnt;
  logic [64:0] shifted;
  logic [64:0] diff;
  logic        qbit;
  logic [63:0] rem_next;

  // One quotient bit per cycle, restoring form
  always_comb begin
    shifted  = {rem, dvd[63]};
    diff     = shifted - {1'b0, dvs};
    qbit     = (shifted >= {1'b0, dvs});
    rem_next = qbit ? diff[63:0] : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (dvs == 64'd0 || hi >= dvs) begin
          quo  <= '1;
          done <= 1'b1;
        end else begin
          rem  <= hi;
          dvd  <= lo;
          quo  <= '0;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[62:0], 1'b0};
        quo <= {quo[62:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/wrv_back.sv =====
module wrv_back import wrv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    res_valid,
  output result_t res,
  input  logic    res_pop
);

  localparam logic [5:0] MUL_LAST = 6'd32;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_AW, S_QDIV_GO, S_QDIV, S_MEAN, S_MUL, S_DACC,
    S_STATS, S_SW, S_POPDIV, S_POPSQ, S_SMPDIV, S_SMPSQ, S_DONE
  } state_t;

  state_t      state;
  item_t       item;
  logic [47:0] wsum;
  logic [63:0] ssum;
  logic [31:0] mean;
  logic [63:0] dsum;
  logic        first;
  logic [32:0] a;
  logic        neg;
  logic [47:0] aw;
  logic [79:0] acc;
  logic [79:0] cand;
  logic [32:0] mb;
  logic [5:0]  mcnt;
  logic [63:0] sw;
  logic [63:0] sq_v;
  logic [63:0] sq_res;
  logic [63:0] sq_bit;
  logic [31:0] pop_sd;
  logic [31:0] samp_sd;
  logic        undef;
  logic        div_start;
  logic [63:0] div_hi;
  logic [63:0] div_lo;
  logic [63:0] div_d;
  logic        div_busy;
  logic        div_done;
  logic [63:0] div_quo;

  logic [48:0] w_add;
  logic [64:0] s_add;
  logic [32:0] delta;
  logic [33:0] m_new;
  logic [32:0] b_s;
  logic [64:0] d_add;
  logic [63:0] sq_sum;
  logic        sq_ge;
  logic [63:0] sq_res_n;
  logic [63:0] sq_v_n;

  wrv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .hi    (div_hi),
    .lo    (div_lo),
    .dvs   (div_d),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    w_add    = {1'b0, wsum} + {34'b0, item.weight};
    s_add    = {1'b0, ssum} + {35'b0, {15'b0, item.weight} * {15'b0, item.weight}};
    delta    = {item.value[31], item.value} - {mean[31], mean};
    m_new    = neg ? ({{2{mean[31]}}, mean} - {1'b0, div_quo[32:0]})
                   : ({{2{mean[31]}}, mean} + {1'b0, div_quo[32:0]});
    b_s      = {item.value[31], item.value} - {mean[31], mean};
    d_add    = {1'b0, dsum} + {9'b0, acc[79:24]};
    sq_sum   = sq_res + sq_bit;
    sq_ge    = (sq_v >= sq_sum);
    sq_res_n = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
    sq_v_n   = sq_ge ? (sq_v - sq_sum) : sq_v;
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wsum      <= '0;
      ssum      <= '0;
      mean      <= '0;
      dsum      <= '0;
      first     <= 1'b1;
      div_start <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item  <= q_item;
            state <= (q_item.kind == KIND_ACCEPT) ? S_UPD : S_STATS;
          end
        end
        S_UPD: begin
          wsum <= w_add[48] ? '1 : w_add[47:0];
          ssum <= s_add[64] ? '1 : s_add[63:0];
          if (first) begin
            mean  <= item.value;
            dsum  <= '0;
            first <= 1'b0;
            state <= S_STATS;
          end else begin
            neg   <= delta[32];
            a     <= delta[32] ? (33'd0 - delta) : delta;
            state <= S_AW;
          end
        end
        S_AW: begin
          aw    <= {15'b0, a} * {33'b0, item.weight};
          state <= S_QDIV_GO;
        end
        S_QDIV_GO: begin
          div_hi    <= '0;
          div_lo    <= {16'b0, aw} + {17'b0, wsum[47:1]};
          div_d     <= {16'b0, wsum};
          div_start <= 1'b1;
          state     <= S_QDIV;
        end
        S_QDIV: begin
          if (div_done) begin
            mean  <= m_new[31:0];
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          mb    <= b_s[32] ? (33'd0 - b_s) : b_s;
          cand  <= {32'b0, aw};
          acc   <= '0;
          mcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mb[0]) begin
            acc <= acc + cand;
          end
          cand <= {cand[78:0], 1'b0};
          mb   <= mb >> 1;
          mcnt <= mcnt + 1'b1;
          if (mcnt == MUL_LAST) begin
            state <= S_DACC;
          end
        end
        S_DACC: begin
          dsum  <= d_add[64] ? '1 : d_add[63:0];
          state <= S_STATS;
        end
        S_STATS: begin
          if (wsum == 48'd0) begin
            pop_sd  <= '0;
            samp_sd <= '0;
            undef   <= 1'b1;
            state   <= S_DONE;
          end else begin
            div_hi    <= '0;
            div_lo    <= ssum;
            div_d     <= {16'b0, wsum};
            div_start <= 1'b1;
            state     <= S_SW;
          end
        end
        S_SW: begin
          if (div_done) begin
            sw        <= div_quo;
            div_hi    <= {40'b0, dsum[63:40]};
            div_lo    <= {dsum[39:0], 24'b0};
            div_d     <= {16'b0, wsum};
            div_start <= 1'b1;
            state     <= S_POPDIV;
          end
        end
        S_POPDIV: begin
          if (div_done) begin
            sq_v   <= div_quo;
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            state  <= S_POPSQ;
          end
        end
        S_POPSQ: begin
          sq_v   <= sq_v_n;
          sq_res <= sq_res_n;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            pop_sd <= sq_res_n[31:0];
            if (sw < {16'b0, wsum}) begin
              div_hi    <= {40'b0, dsum[63:40]};
              div_lo    <= {dsum[39:0], 24'b0};
              div_d     <= {16'b0, wsum - sw[47:0]};
              div_start <= 1'b1;
              state     <= S_SMPDIV;
            end else begin
              samp_sd <= '0;
              undef   <= 1'b1;
              state   <= S_DONE;
            end
          end
        end
        S_SMPDIV: begin
          if (div_done) begin
            sq_v   <= div_quo;
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            state  <= S_SMPSQ;
          end
        end
        S_SMPSQ: begin
          sq_v   <= sq_v_n;
          sq_res <= sq_res_n;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            samp_sd <= sq_res_n[31:0];
            undef   <= 1'b0;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid) begin
            res_valid    <= 1'b1;
            res.mean     <= mean;
            res.pop_sd   <= pop_sd;
            res.samp_sd  <= samp_sd;
            res.rejected <= (item.kind == KIND_REJECT);
            res.undef    <= undef;
            res.empty    <= first;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_first_has_weight: assert property (@(posedge clk) disable iff (rst)
    !first |-> (wsum != 48'd0))
    else $error("statistics hold samples but weight sum is zero");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_pop) |=> (res_valid && $stable(res)))
    else $error("pending result dropped or changed");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_UPD || state == S_STATS))
    else $error("item taken outside idle");
`endif

endmodule

// ===== rtl/weighted_running_variance_top.sv =====
// Weighted running mean and standard deviation (weighted Welford update).
//
// Input channel: drive sample_value (Q16.16) and sample_weight (Q8.8) with
// push; a transfer happens on a rising edge with push high and full low.
// Result channel: while empty is low the oldest result sits on mean_out,
// pop_std_dev, sample_std_dev and the three flags; pop transfers it.
// Every input transfer yields exactly one result, in order.
//
// An accepted item runs the shared 64-step divider up to four times and the
// 32-step square root up to twice; a rejected or zero-weight item runs the
// divider up to three times and the root up to twice.
// Before the first accepted sample an item runs no division and no root.
// The back end takes one item at a time; a two-entry input queue
// takes items while the back end is busy.
//
// Reset (rst, synchronous) clears the statistics, empties both queues and
// marks the block empty. When the receiver stalls, the finished result is
// held in the output register and the back end waits; the input queue
// keeps taking items until it fills, then raises full.
module weighted_running_variance_top import wrv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] sample_value,
  input  logic [15:0] sample_weight,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] mean_out,
  output logic [31:0] pop_std_dev,
  output logic [31:0] sample_std_dev,
  output logic        weight_rejected,
  output logic        sample_undefined,
  output logic        is_empty
);

  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  logic    res_valid;
  result_t res;

  // Front end: transfer, classify by weight sign and zero weight, queue
  wrv_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .value   (sample_value),
    .weight  (sample_weight),
    .full    (full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // Back end: update the sums, then divide and take roots on shared units
  wrv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  // Present the output register
  assign empty            = !res_valid;
  assign mean_out         = res.mean;
  assign pop_std_dev      = res.pop_sd;
  assign sample_std_dev   = res.samp_sd;
  assign weight_rejected  = res.rejected;
  assign sample_undefined = res.undef;
  assign is_empty         = res.empty;

endmodule

// ===== tb/tb.sv =====
module tb;
  import wrv_pkg::*;

  localparam logic [47:0] WSUM_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int RANDOM_ITEMS = 1650;
  localparam int HOLD_CYCLES = 3000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [31:0] sample_value;
  logic [15:0] sample_weight;
  logic        empty;
  logic        pop;
  logic [31:0] mean_out;
  logic [31:0] pop_std_dev;
  logic [31:0] sample_std_dev;
  logic        weight_rejected;
  logic        sample_undefined;
  logic        is_empty;

  weighted_running_variance_top u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .sample_value(sample_value),
    .sample_weight(sample_weight),
    .empty(empty),
    .pop(pop),
    .mean_out(mean_out),
    .pop_std_dev(pop_std_dev),
    .sample_std_dev(sample_std_dev),
    .weight_rejected(weight_rejected),
    .sample_undefined(sample_undefined),
    .is_empty(is_empty)
  );

  // Shadow copy of the running statistics
  logic [47:0] wsum;      // sum of weights, Q40.8
  logic [63:0] sqsum;     // sum of squared weights, Q48.16
  longint      run_mean;  // running mean, Q16.16 sign-extended
  logic [63:0] dev_sum;   // weighted squared deviations
  bit          first_pending;

  result_t pending_stats[$];   // expected results, oldest first

  int  mismatches = 0;
  bit  calm = 0;        // no idling on either side while set
  bit  hold_off = 0;    // receiver stalls while set
  int  items_sent = 0;

  // Clock: period 8
  initial clk = 0;
  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Floor square root of a 64-bit value
  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  // Root of (D << 24) / divisor, quotient saturated at 64 bits
  function automatic logic [31:0] deviation_root(input logic [63:0] divisor);
    logic [127:0] num;
    logic [127:0] quo;
    num = {64'd0, dev_sum} << 24;
    quo = num / {64'd0, divisor};
    if (quo[127:64] != 0) quo = {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
    return floor_root(quo[63:0]);
  endfunction

  // Fold one sample into the statistics and produce the reported result
  function automatic result_t welford_update(input logic [31:0] v, input logic [15:0] w);
    result_t r;
    longint x;
    logic [63:0] wt;
    logic [63:0] nw;
    logic [64:0] ns;
    longint delta;
    longint bs;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] q;
    logic [127:0] prod;
    logic [64:0] nd;
    logic [63:0] sw;
    x = longint'(signed'(v));
    wt = {48'd0, w};
    r = '0;
    r.rejected = w[15];
    if (!w[15] && w != 0) begin
      nw = {16'd0, wsum} + wt;
      wsum = (nw > {16'd0, WSUM_MAX}) ? WSUM_MAX : nw[47:0];
      ns = {1'b0, sqsum} + {1'b0, wt * wt};
      sqsum = ns[64] ? 64'hFFFF_FFFF_FFFF_FFFF : ns[63:0];
      if (first_pending) begin
        run_mean = x;
        dev_sum = 0;
        first_pending = 0;
      end else begin
        delta = x - run_mean;
        a = (delta < 0) ? -delta : delta;
        q = (a * wt + {17'd0, wsum[47:1]}) / {16'd0, wsum};
        if (delta < 0) run_mean = run_mean - longint'(q);
        else run_mean = run_mean + longint'(q);
        bs = x - run_mean;
        b = (bs < 0) ? -bs : bs;
        prod = {64'd0, a * wt} * {64'd0, b};
        nd = {1'b0, dev_sum} + {1'b0, prod[87:24]};
        dev_sum = nd[64] ? 64'hFFFF_FFFF_FFFF_FFFF : nd[63:0];
      end
    end
    r.undef = 1;
    if (wsum != 0) begin
      sw = sqsum / {16'd0, wsum};
      r.pop_sd = deviation_root({16'd0, wsum});
      if (sw < {16'd0, wsum}) begin
        r.undef = 0;
        r.samp_sd = deviation_root({16'd0, wsum} - sw);
      end
    end
    r.mean = run_mean[31:0];
    r.empty = first_pending;
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then record what it should report
  task automatic transfer_item(input logic [31:0] v, input logic [15:0] w,
                               input bit typed, input result_t typed_res);
    result_t r;
    while (!calm && $urandom_range(99) < 21) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    sample_value <= v;
    sample_weight <= w;
    do @(posedge clk); while (full);
    r = welford_update(v, w);
    pending_stats.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  function automatic result_t stats_of(input logic [31:0] m, input logic [31:0] p,
                                       input logic [31:0] s, input bit rej,
                                       input bit und, input bit emp);
    result_t r;
    r.mean = m;
    r.pop_sd = p;
    r.samp_sd = s;
    r.rejected = rej;
    r.undef = und;
    r.empty = emp;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(4 << 16))) - (32'd2 << 16);
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    int k;
    k = $urandom_range(99);
    if (k < 8) return 16'h8000 | 16'($urandom);   // rejected
    if (k < 16) return 16'h0000;                  // ignored
    if (k < 22) return 16'h7FFF;
    if (k < 26) return 16'h0001;
    if (k < 60) return 16'($urandom_range(16'h0200, 16'h0040));
    return 16'($urandom_range(16'h7FFF, 16'h0001));
  endfunction

  // Stimulus
  typedef struct {
    logic [31:0] v;
    logic [15:0] w;
    bit          typed;
    result_t     res;
  } stim_row_t;

  stim_row_t stim_rows[$];

  initial begin
    result_t none;
    int n;
    none = '0;
    rst = 1;
    push = 0;
    sample_value = 0;
    sample_weight = 0;
    wsum = 0;
    sqsum = 0;
    run_mean = 0;
    dev_sum = 0;
    first_pending = 1;

    // Empty: zero weight and rejected weights report the reset state
    stim_rows.push_back('{32'h0000_0000, 16'h0000, 1, stats_of(0, 0, 0, 0, 1, 1)});
    stim_rows.push_back('{32'h7FFF_FFFF, 16'hFFFF, 1, stats_of(0, 0, 0, 1, 1, 1)});
    stim_rows.push_back('{32'h8000_0000, 16'h8000, 1, stats_of(0, 0, 0, 1, 1, 1)});
    // First sample sets the mean; one weight source leaves the sample case undefined
    stim_rows.push_back('{32'h0001_0000, 16'h0100, 1,
                          stats_of(32'h0001_0000, 0, 0, 0, 1, 0)});
    stim_rows.push_back('{32'h0001_0000, 16'h0000, 1,
                          stats_of(32'h0001_0000, 0, 0, 0, 1, 0)});
    stim_rows.push_back('{32'h1234_5678, 16'hC000, 1,
                          stats_of(32'h0001_0000, 0, 0, 1, 1, 0)});
    // Extremes of value and weight
    stim_rows.push_back('{32'h7FFF_FFFF, 16'h7FFF, 0, none});
    stim_rows.push_back('{32'h8000_0000, 16'h7FFF, 0, none});
    stim_rows.push_back('{32'h7FFF_FFFF, 16'h0001, 0, none});
    stim_rows.push_back('{32'h8000_0000, 16'h0001, 0, none});
    stim_rows.push_back('{32'h0000_0000, 16'h0100, 0, none});
    stim_rows.push_back('{32'hFFFF_FFFF, 16'h0080, 0, none});
    stim_rows.push_back('{32'h5555_AAAA, 16'h5555, 0, none});
    stim_rows.push_back('{32'hAAAA_5555, 16'h2AAA, 0, none});
    stim_rows.push_back('{32'h0000_0001, 16'h7FFF, 0, none});
    stim_rows.push_back('{32'h0000_0001, 16'h0000, 0, none});
    stim_rows.push_back('{32'h0000_0001, 16'hFFFF, 0, none});

    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (stim_rows[i])
      transfer_item(stim_rows[i].v, stim_rows[i].w, stim_rows[i].typed, stim_rows[i].res);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      calm = (n >= 600 && n < 800);
      if ($urandom_range(19) == 0) begin
        // Burst of alternating extremes to drive the deviation sum toward saturation
        repeat (20) begin
          transfer_item(n[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 16'h7FFF, 0, none);
          n++;
        end
      end else begin
        transfer_item(pick_value(), pick_weight(), 0, none);
        n++;
      end
    end
    push <= 0;
    calm = 0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Long receiver stall once the run is under way, so the input queue fills
  initial begin
    int cnt;
    wait (items_sent == 100);
    hold_off = 1;
    for (cnt = 0; cnt < HOLD_CYCLES; cnt++) @(posedge clk);
    hold_off = 0;
  end

  // Receiver: check each transfer against the oldest expectation, then pick pop
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        if (pending_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result, mean %h", mean_out);
        end else begin
          e = pending_stats.pop_front();
          if (mean_out !== e.mean || pop_std_dev !== e.pop_sd ||
              sample_std_dev !== e.samp_sd || weight_rejected !== e.rejected ||
              sample_undefined !== e.undef || is_empty !== e.empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp mean %h pop %h samp %h rej %b und %b emp %b / got %h %h %h %b %b %b",
                       e.mean, e.pop_sd, e.samp_sd, e.rejected, e.undef, e.empty,
                       mean_out, pop_std_dev, sample_std_dev, weight_rejected,
                       sample_undefined, is_empty);
          end
        end
      end
      pop <= !hold_off && (calm || $urandom_range(99) >= 21);
    end
  end

  // Watchdog
  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== weighted_running_variance_top.f =====
rtl/wrv_pkg.sv
rtl/wrv_front.sv
rtl/wrv_div.sv
rtl/wrv_back.sv
rtl/weighted_running_variance_top.sv
tb/tb.sv
